/* design/owbm_pkg.sv */
// Package: shared types and constants for the one-wire bus master unit.
`default_nettype none

package owbm_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 10;

   localparam logic [CSR_INDEX_W-1:0] CSR_RESET_LOW     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESET_RELEASE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOT_START    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WRITE_HOLD    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RECOVERY      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_READ_SAMPLE   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_READ_TAIL     = 3'd6;

   localparam logic [9:0] RESET_LOW_INIT     = 10'd500;
   localparam logic [9:0] RESET_RELEASE_INIT = 10'd500;
   localparam logic [3:0] SLOT_START_INIT    = 4'd2;
   localparam logic [6:0] WRITE_HOLD_INIT    = 7'd60;
   localparam logic [3:0] RECOVERY_INIT      = 4'd2;
   localparam logic [5:0] READ_SAMPLE_INIT   = 6'd8;
   localparam logic [7:0] READ_TAIL_INIT     = 8'd120;

   localparam logic [1:0] ACT_TICK = 2'd0;

   typedef enum logic [1:0] {
      OP_IDLE  = 2'd0,
      OP_RESET = 2'd1,
      OP_WRITE = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      PH_START = 2'd0,
      PH_MID   = 2'd1,
      PH_END   = 2'd2
   } phase_type;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] write_value;
      logic       line_level;
   } req_item_type;

   typedef struct packed {
      logic       drive_low;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_value;
      logic       rejected;
   } rsp_item_type;

   typedef struct packed {
      logic       is_cmd;
      op_type     op;
      logic [7:0] write_value;
      logic       line_level;
   } cls_item_type;

endpackage

`default_nettype wire

/* design/owbm_front.sv */
// Front end: classifies incoming items and holds them in a short queue.
`default_nettype none

module owbm_front
   import owbm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output      logic         req_ready,
   input  wire req_item_type req_item,
   input  wire logic         pop,
   output      logic         head_valid,
   output      cls_item_type head
);

   cls_item_type              queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]         count_ff, count_in;
   cls_item_type              cls;
   logic                      push;
   logic                      do_pop;

   always_comb begin
      cls.is_cmd      = (req_item.action != ACT_TICK);
      cls.op          = op_type'(req_item.action);
      cls.write_value = req_item.write_value;
      cls.line_level  = req_item.line_level;
   end

   assign req_ready  = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = queue_ff[rd_ptr_ff];
   assign push       = req_valid && req_ready;
   assign do_pop     = pop && head_valid;

   // depth is a power of two, so pointers wrap naturally
   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

`default_nettype wire

/* design/owbm_back.sv */
// Back end: slot sequencer, timing registers and result register.
`default_nettype none

module owbm_back
   import owbm_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   head_valid,
   input  wire cls_item_type           head,
   output      logic                   pop,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      rsp_item_type           rsp_item,
   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   logic [9:0] reset_low_ff, reset_release_ff;
   logic [3:0] slot_start_ff, recovery_ff;
   logic [6:0] write_hold_ff;
   logic [5:0] read_sample_ff;
   logic [7:0] read_tail_ff;

   op_type     op_ff, op_in;
   phase_type  phase_ff, phase_in;
   logic [2:0] bit_ff, bit_in;
   logic [9:0] time_ff, time_in;
   logic [7:0] shift_ff, shift_in;
   logic       pull_ff, pull_in;
   logic [7:0] last_ff, last_in;
   logic       done, rej;
   logic [9:0] time_dec;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff;

   function automatic logic [9:0] dur(input logic [9:0] v);
      return (v == '0) ? 10'd1 : v;
   endfunction

   assign csr_ready = 1'b1;
   assign pop       = head_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;
   assign time_dec  = (time_ff != '0) ? time_ff - 10'd1 : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         reset_low_ff     <= RESET_LOW_INIT;
         reset_release_ff <= RESET_RELEASE_INIT;
         slot_start_ff    <= SLOT_START_INIT;
         write_hold_ff    <= WRITE_HOLD_INIT;
         recovery_ff      <= RECOVERY_INIT;
         read_sample_ff   <= READ_SAMPLE_INIT;
         read_tail_ff     <= READ_TAIL_INIT;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_RESET_LOW:     reset_low_ff     <= csr_data;
            CSR_RESET_RELEASE: reset_release_ff <= csr_data;
            CSR_SLOT_START:    slot_start_ff    <= csr_data[3:0];
            CSR_WRITE_HOLD:    write_hold_ff    <= csr_data[6:0];
            CSR_RECOVERY:      recovery_ff      <= csr_data[3:0];
            CSR_READ_SAMPLE:   read_sample_ff   <= csr_data[5:0];
            CSR_READ_TAIL:     read_tail_ff     <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      op_in    = op_ff;
      phase_in = phase_ff;
      bit_in   = bit_ff;
      time_in  = time_ff;
      shift_in = shift_ff;
      pull_in  = pull_ff;
      last_in  = last_ff;
      done     = 1'b0;
      rej      = 1'b0;
      if (pop) begin
         if (head.is_cmd) begin
            if (op_ff != OP_IDLE) begin
               rej = 1'b1;
            end else begin
               op_in    = head.op;
               phase_in = PH_START;
               bit_in   = '0;
               pull_in  = 1'b1;
               if (head.op == OP_WRITE) begin
                  shift_in = head.write_value;
               end
               time_in = (head.op == OP_RESET) ? dur(reset_low_ff)
                                               : dur({6'd0, slot_start_ff});
            end
         end else if (op_ff != OP_IDLE) begin
            time_in = time_dec;
            if (time_dec == '0) begin
               unique case (op_ff)
                  OP_RESET: begin
                     if (phase_ff == PH_START) begin
                        phase_in = PH_MID;
                        pull_in  = 1'b0;
                        time_in  = dur(reset_release_ff);
                     end else begin
                        done = 1'b1;
                     end
                  end
                  OP_WRITE: begin
                     if (phase_ff == PH_START) begin
                        phase_in = PH_MID;
                        pull_in  = ~shift_ff[0];
                        shift_in = {1'b0, shift_ff[7:1]};
                        time_in  = dur({3'd0, write_hold_ff});
                     end else if (phase_ff == PH_MID) begin
                        phase_in = PH_END;
                        pull_in  = 1'b0;
                        time_in  = dur({6'd0, recovery_ff});
                     end else begin
                        done = (bit_ff == 3'd7);
                     end
                  end
                  OP_READ: begin
                     if (phase_ff == PH_START) begin
                        phase_in = PH_MID;
                        pull_in  = 1'b0;
                        time_in  = dur({4'd0, read_sample_ff});
                     end else if (phase_ff == PH_MID) begin
                        phase_in = PH_END;
                        pull_in  = 1'b0;
                        shift_in = {head.line_level, shift_ff[7:1]};
                        time_in  = dur({2'd0, read_tail_ff});
                     end else begin
                        done = (bit_ff == 3'd7);
                        if (done) begin
                           last_in = shift_ff;
                        end
                     end
                  end
                  default: ;
               endcase
               if (phase_ff == PH_END && op_ff != OP_RESET && !done) begin
                  bit_in   = bit_ff + 3'd1;
                  phase_in = PH_START;
                  pull_in  = 1'b1;
                  time_in  = dur({6'd0, slot_start_ff});
               end
               if (done) begin
                  op_in    = OP_IDLE;
                  phase_in = PH_START;
                  bit_in   = '0;
                  time_in  = '0;
                  pull_in  = 1'b0;
               end
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff        <= OP_IDLE;
         phase_ff     <= PH_START;
         bit_ff       <= '0;
         time_ff      <= '0;
         shift_ff     <= '0;
         pull_ff      <= 1'b0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         op_ff        <= op_in;
         phase_ff     <= phase_in;
         bit_ff       <= bit_in;
         time_ff      <= time_in;
         shift_ff     <= shift_in;
         pull_ff      <= pull_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_item_ff.drive_low  <= pull_in;
         rsp_item_ff.busy_res   <= (op_in != OP_IDLE);
         rsp_item_ff.done_res   <= done;
         rsp_item_ff.read_value <= last_in;
         rsp_item_ff.rejected   <= rej;
      end
   end

endmodule

`default_nettype wire

/* design/one_wire_bus_master_unit.sv */
// Top level: one-wire bus master unit.
// Path: an accepted item is written into the queue, then popped into the result register;
// a stall on the result side holds it in the queue.
// Throughput: one item per clock cycle while the result side accepts; the sequencer updates once per item.
// Reset: synchronous; queue and result register empty, sequencer idle, line released,
// timing registers at their default values.
`default_nettype none

module one_wire_bus_master_unit
   import owbm_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_ready,
   input  wire req_item_type           req_item,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      rsp_item_type           rsp_item,
   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   logic         head_valid;
   cls_item_type head;
   logic         pop;

   owbm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   owbm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_item   (rsp_item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

endmodule

`default_nettype wire

/* tb/one_wire_bus_master_unit_tb.sv */
// Testbench: scoreboard-checked random and directed traffic for the one-wire bus master unit.
module one_wire_bus_master_unit_tb;
   import owbm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT     = 2000;
   localparam int RSP_HOLD_CYCLES = 200;
   localparam int TAIL_CYCLES     = 10;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 3'd7;

   typedef enum int {LINE_LOW, LINE_HIGH, LINE_RANDOM} line_kind_type;
   typedef logic [CSR_DATA_W-1:0] timing_set_type [8];

   class bus_master_scoreboard;
      logic [9:0]   timing [7];
      op_type       operation;
      phase_type    phase;
      logic [2:0]   bit_no;
      logic [9:0]   remaining;
      logic [7:0]   shifter;
      logic         pull;
      logic [7:0]   last_byte;
      rsp_item_type expected_line_states [$];
      int n_items, n_checked, n_fail, n_commands, n_rejected, n_done;

      function new();
         timing[CSR_RESET_LOW]     = RESET_LOW_INIT;
         timing[CSR_RESET_RELEASE] = RESET_RELEASE_INIT;
         timing[CSR_SLOT_START]    = SLOT_START_INIT;
         timing[CSR_WRITE_HOLD]    = WRITE_HOLD_INIT;
         timing[CSR_RECOVERY]      = RECOVERY_INIT;
         timing[CSR_READ_SAMPLE]   = READ_SAMPLE_INIT;
         timing[CSR_READ_TAIL]     = READ_TAIL_INIT;
         shifter   = '0;
         last_byte = '0;
         go_idle();
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_RESET_LOW, CSR_RESET_RELEASE: timing[idx] = val;
            CSR_SLOT_START, CSR_RECOVERY:     timing[idx] = val & 10'h00F;
            CSR_WRITE_HOLD:                   timing[idx] = val & 10'h07F;
            CSR_READ_SAMPLE:                  timing[idx] = val & 10'h03F;
            CSR_READ_TAIL:                    timing[idx] = val & 10'h0FF;
            default: ;
         endcase
      endfunction

      function void go_idle();
         operation = OP_IDLE;
         phase     = PH_START;
         bit_no    = '0;
         remaining = '0;
         pull      = 1'b0;
      endfunction

      // a zero register counts as one microsecond
      function void enter(phase_type ph, logic pull_low, logic [CSR_INDEX_W-1:0] idx);
         phase     = ph;
         pull      = pull_low;
         remaining = (timing[idx] == 0) ? 10'd1 : timing[idx];
      endfunction

      function logic slot_over();
         if (bit_no == 3'd7) begin
            if (operation == OP_READ)
               last_byte = shifter;
            go_idle();
            return 1'b1;
         end
         bit_no = bit_no + 3'd1;
         enter(PH_START, 1'b1, CSR_SLOT_START);
         return 1'b0;
      endfunction

      function void note_item(req_item_type it);
         rsp_item_type want;
         logic done, rej, b;
         done = 1'b0;
         rej  = 1'b0;
         n_items++;
         if (it.action != ACT_TICK) begin
            if (operation != OP_IDLE) begin
               rej = 1'b1;
               n_rejected++;
            end else begin
               n_commands++;
               operation = op_type'(it.action);
               bit_no    = '0;
               if (operation == OP_WRITE)
                  shifter = it.write_value;
               enter(PH_START, 1'b1, operation == OP_RESET ? CSR_RESET_LOW : CSR_SLOT_START);
            end
         end else if (operation != OP_IDLE) begin
            if (remaining > 0)
               remaining = remaining - 10'd1;
            if (remaining == 0) begin
               case (operation)
                  OP_RESET: begin
                     if (phase == PH_START) begin
                        enter(PH_MID, 1'b0, CSR_RESET_RELEASE);
                     end else begin
                        go_idle();
                        done = 1'b1;
                     end
                  end
                  OP_WRITE: begin
                     case (phase)
                        PH_START: begin
                           b       = shifter[0];
                           shifter = {1'b0, shifter[7:1]};
                           enter(PH_MID, ~b, CSR_WRITE_HOLD);
                        end
                        PH_MID:  enter(PH_END, 1'b0, CSR_RECOVERY);
                        default: done = slot_over();
                     endcase
                  end
                  default: begin
                     case (phase)
                        PH_START: enter(PH_MID, 1'b0, CSR_READ_SAMPLE);
                        PH_MID: begin
                           shifter = {it.line_level, shifter[7:1]};
                           enter(PH_END, 1'b0, CSR_READ_TAIL);
                        end
                        default: done = slot_over();
                     endcase
                  end
               endcase
            end
         end
         if (done)
            n_done++;
         want.drive_low  = pull;
         want.busy_res   = (operation != OP_IDLE);
         want.done_res   = done;
         want.read_value = last_byte;
         want.rejected   = rej;
         expected_line_states.push_back(want);
      endfunction

      function void compare(string field, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            n_fail++;
         end
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type want;
         n_checked++;
         if (expected_line_states.size() == 0) begin
            $error("result with nothing expected: %p", got);
            n_fail++;
            return;
         end
         want = expected_line_states.pop_front();
         compare("drive_low", 8'(want.drive_low), 8'(got.drive_low));
         compare("busy_res", 8'(want.busy_res), 8'(got.busy_res));
         compare("done_res", 8'(want.done_res), 8'(got.done_res));
         compare("read_value", want.read_value, got.read_value);
         compare("rejected", 8'(want.rejected), 8'(got.rejected));
      endfunction

      function int pending();
         return expected_line_states.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_item_type           req_item;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_item_type           rsp_item;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   bus_master_scoreboard sb;
   bit req_calm, rsp_calm, hold_rsp;
   int n_settings;
   int quiet = 0;

   one_wire_bus_master_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned pick_gap(input bit calm);
      int unsigned r;
      if (calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      if (r < 98)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_span(input int unsigned top);
      if ($urandom_range(0, 9) < 7)
         return CSR_DATA_W'($urandom_range(0, 4));
      return CSR_DATA_W'($urandom_range(0, top));
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_item);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet >= STALL_LIMIT) begin
         $display("no handshake for %0d cycles", STALL_LIMIT);
         $display("one_wire_bus_master_unit: mismatch");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   // result side: random stalls, plus a long hold-off on request
   initial begin
      int unsigned gap;
      rsp_ready = 1'b0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(negedge clock);
         end
         gap = pick_gap(rsp_calm);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(negedge clock);
      end
   end

   task automatic offer(input logic [1:0] action, input logic [7:0] value, input logic level);
      req_item_type it;
      int unsigned gap;
      it.action      = action;
      it.write_value = value;
      it.line_level  = level;
      req_item  <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.note_item(it);
      @(negedge clock);
      gap = pick_gap(req_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic ticks_until_idle(input line_kind_type kind);
      logic level;
      while (sb.operation != OP_IDLE) begin
         case (kind)
            LINE_LOW:  level = 1'b0;
            LINE_HIGH: level = 1'b1;
            default:   level = 1'($urandom_range(0, 1));
         endcase
         offer(ACT_TICK, 8'($urandom), level);
      end
   endtask

   task automatic run_command(input op_type op, input logic [7:0] value,
                              input line_kind_type kind);
      offer(op, value, 1'($urandom_range(0, 1)));
      ticks_until_idle(kind);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic program_timing(input timing_set_type vals);
      int i;
      for (i = 0; i < 8; i++) begin
         csr_index <= CSR_INDEX_W'(i);
         csr_data  <= vals[i];
         csr_valid <= 1'b1;
         do @(posedge clock); while (!csr_ready);
         sb.write_reg(CSR_INDEX_W'(i), vals[i]);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
      n_settings++;
   endtask

   task automatic roll_timing(output timing_set_type ts);
      ts[CSR_RESET_LOW]     = pick_span(40);
      ts[CSR_RESET_RELEASE] = pick_span(40);
      ts[CSR_SLOT_START]    = pick_span(15);
      ts[CSR_WRITE_HOLD]    = pick_span(30);
      ts[CSR_RECOVERY]      = pick_span(15);
      ts[CSR_READ_SAMPLE]   = pick_span(15);
      ts[CSR_READ_TAIL]     = pick_span(30);
      ts[CSR_SPARE]         = CSR_DATA_W'($urandom);
   endtask

   task automatic random_traffic(input int unsigned count);
      int unsigned k;
      int unsigned r;
      for (k = 0; k < count || sb.operation != OP_IDLE; k++) begin
         r = $urandom_range(0, 99);
         if ((sb.operation == OP_IDLE && r < 75) || (sb.operation != OP_IDLE && r < 4))
            offer(2'($urandom_range(1, 3)), 8'($urandom), 1'($urandom_range(0, 1)));
         else
            offer(ACT_TICK, 8'($urandom), 1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      timing_set_type ts;
      int p, i;
      sb         = new();
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_item   = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      req_calm   = 1'b0;
      rsp_calm   = 1'b0;
      hold_rsp   = 1'b0;
      n_settings = 1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // power-up timings: idle ticks, busy refusals, one write byte
      offer(ACT_TICK, 8'hFF, 1'b1);
      offer(ACT_TICK, 8'h00, 1'b0);
      offer(OP_WRITE, 8'h5A, 1'b0);
      offer(OP_RESET, 8'hFF, 1'b1);
      offer(OP_READ, 8'h00, 1'b0);
      offer(OP_WRITE, 8'hFF, 1'b1);
      ticks_until_idle(LINE_RANDOM);
      settle();

      // all timings zero, so every phase lasts one tick
      for (i = 0; i < 7; i++)
         ts[i] = '0;
      ts[CSR_SPARE] = '1;
      program_timing(ts);
      run_command(OP_WRITE, 8'hFF, LINE_RANDOM);
      run_command(OP_WRITE, 8'h00, LINE_RANDOM);
      run_command(OP_READ, 8'h00, LINE_HIGH);
      offer(OP_WRITE, 8'h00, 1'b0);
      run_command(OP_READ, 8'hFF, LINE_LOW);
      run_command(OP_RESET, 8'h00, LINE_RANDOM);
      settle();

      // data bits above each narrow register's width set, so only the low bits count
      ts[CSR_RESET_LOW]     = 10'd3;
      ts[CSR_RESET_RELEASE] = 10'd2;
      ts[CSR_SLOT_START]    = 10'h3F0;
      ts[CSR_WRITE_HOLD]    = 10'h382;
      ts[CSR_RECOVERY]      = 10'h3F2;
      ts[CSR_READ_SAMPLE]   = 10'h3C1;
      ts[CSR_READ_TAIL]     = 10'h303;
      ts[CSR_SPARE]         = '1;
      program_timing(ts);
      run_command(OP_RESET, 8'h00, LINE_RANDOM);
      run_command(OP_WRITE, 8'h81, LINE_RANDOM);
      run_command(OP_READ, 8'h00, LINE_RANDOM);
      settle();

      for (p = 0; p < 4; p++) begin
         roll_timing(ts);
         program_timing(ts);
         req_calm = (p == 1 || p == 2);
         rsp_calm = (p == 2);
         hold_rsp = (p == 1);
         random_traffic(110);
         settle();
      end
      req_calm = 1'b0;
      rsp_calm = 1'b0;

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("%0d items sent, %0d results checked; %0d commands run, %0d refused as busy, %0d done",
               sb.n_items, sb.n_checked, sb.n_commands, sb.n_rejected, sb.n_done);
      $display("%0d timing settings used, from power-up and all-zero to random short ones",
               n_settings);
      if (sb.n_fail == 0 && sb.pending() == 0)
         $display("one_wire_bus_master_unit: match");
      else
         $display("one_wire_bus_master_unit: mismatch");
      $finish;
   end

endmodule

/* sim.f */
design/owbm_pkg.sv
design/owbm_front.sv
design/owbm_back.sv
design/one_wire_bus_master_unit.sv
tb/one_wire_bus_master_unit_tb.sv
